### rtl/rsl_pkg.sv
package rsl_pkg;

  localparam int DEFAULT_ADC_BITS = 12;
  localparam int LEVELS           = 5;
  localparam int SEGS             = LEVELS - 1;
  localparam int QW               = 15;
  localparam int PIPE_LAT         = QW + 4;

  localparam logic [QW-1:0] Q8_FAR  = QW'(20480);
  localparam logic [QW-1:0] Q8_NEAR = QW'(1280);
  localparam logic [QW-1:0] Q8_NONE = '0;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_FAR    = 2'd1,
    ST_NEAR   = 2'd2,
    ST_NOSEG  = 2'd3
  } status_t;

  typedef logic [2:0] cfg_idx_t;
  typedef logic [1:0] seg_t;

  localparam cfg_idx_t CFG_LVL_80CM = 3'd0;
  localparam cfg_idx_t CFG_LVL_40CM = 3'd1;
  localparam cfg_idx_t CFG_LVL_10CM = 3'd2;
  localparam cfg_idx_t CFG_LVL_7CM  = 3'd3;
  localparam cfg_idx_t CFG_LVL_5CM  = 3'd4;

  // Reset calibration codes, far to near.
  localparam logic [15:0] LEVEL_RESET [LEVELS] = '{16'd500, 16'd900, 16'd2400,
                                                   16'd3000, 16'd3600};

  // Per segment, numbered from the far end: near distance, distance step and
  // the product of both end distances (all in cm).
  localparam logic [5:0]  SEG_DHI  [SEGS] = '{6'd40, 6'd10, 6'd7, 6'd5};
  localparam logic [5:0]  SEG_DDIF [SEGS] = '{6'd40, 6'd30, 6'd3, 6'd2};
  localparam logic [11:0] SEG_PROD [SEGS] = '{12'd3200, 12'd400, 12'd70, 12'd35};

endpackage

### rtl/ranging_sensor_linearizer_top.sv
// Each sample runs through stages 1 to 3, the divider and the output register. Throughput:
// one sample per cycle while busy is low; three front stages (segment select, products,
// numerator and denominator) feed a 15-stage restoring divider, one quotient bit a stage.
// Reset (synchronous, active high) empties the pipeline, restores the calibration levels
// and holds busy high via rst_hold. The receiver cannot stall; done lasts one cycle.
module ranging_sensor_linearizer_top #(
  parameter int ADC_BITS = rsl_pkg::DEFAULT_ADC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ADC_BITS-1:0]     sample_code,
  input  logic                    cfg_write,
  input  rsl_pkg::cfg_idx_t       cfg_index,
  input  logic [ADC_BITS-1:0]     cfg_data,
  output logic                    done,
  output logic [rsl_pkg::QW-1:0]  distance_q8,
  output rsl_pkg::status_t        range_status
);
  import rsl_pkg::*;

  localparam int AW   = ADC_BITS;
  localparam int MW   = AW + 6;
  localparam int NUMW = AW + 12;
  localparam int DW   = AW + 7;
  localparam int NW   = AW + 21;

  logic [AW-1:0] lvl [LEVELS];
  logic          rst_hold;
  logic          accept;

  assign busy   = rst | rst_hold;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    rst_hold <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) lvl[i] <= AW'(LEVEL_RESET[i]);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LVL_80CM: lvl[0] <= cfg_data;
        CFG_LVL_40CM: lvl[1] <= cfg_data;
        CFG_LVL_10CM: lvl[2] <= cfg_data;
        CFG_LVL_7CM:  lvl[3] <= cfg_data;
        CFG_LVL_5CM:  lvl[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: classify the sample and pick its segment.
  status_t       st_c;
  seg_t          sel_c;
  logic [AW-1:0] lo_c, hi_c;

  always_comb begin
    st_c  = ST_NOSEG;
    sel_c = '0;
    lo_c  = lvl[0];
    hi_c  = lvl[1];
    if (sample_code <= lvl[0]) begin
      st_c = ST_FAR;
    end else if (sample_code > lvl[LEVELS-1]) begin
      st_c = ST_NEAR;
    end else begin
      // Nearer segments win, so the far end is scanned first and overridden.
      for (int s = 0; s < SEGS; s++) begin
        if (sample_code >= lvl[s] && sample_code < lvl[s+1]) begin
          st_c  = ST_INTERP;
          sel_c = seg_t'(s);
          lo_c  = lvl[s];
          hi_c  = lvl[s+1];
        end
      end
      if (st_c == ST_NOSEG && sample_code == lvl[LEVELS-1]) st_c = ST_NEAR;
    end
  end

  logic          s1_vld;
  status_t       s1_st;
  seg_t          s1_sel;
  logic [AW-1:0] s1_off, s1_span;

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= accept;
    s1_st   <= st_c;
    s1_sel  <= sel_c;
    s1_off  <= sample_code - lo_c;
    s1_span <= hi_c - lo_c;
  end

  // Stage 2: the three products.
  logic            s2_vld;
  status_t         s2_st;
  logic [MW-1:0]   s2_den_a, s2_den_b;
  logic [NUMW-1:0] s2_num;

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
    s2_st    <= s1_st;
    s2_den_a <= MW'(SEG_DHI[s1_sel]) * MW'(s1_span);
    s2_den_b <= MW'(SEG_DDIF[s1_sel]) * MW'(s1_off);
    s2_num   <= NUMW'(SEG_PROD[s1_sel]) * NUMW'(s1_span);
  end

  // Stage 3 and the divider stages. Index 0 holds the rounded numerator.
  logic [DW-1:0] den_c;
  assign den_c = DW'(s2_den_a) + DW'(s2_den_b);

  logic          vld_s [QW+1];
  status_t       st_s  [QW+1];
  logic [NW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] q_s   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) vld_s[0] <= 1'b0;
    else     vld_s[0] <= s2_vld;
    st_s[0]  <= s2_st;
    den_s[0] <= den_c;
    rem_s[0] <= NW'({s2_num, 8'h00}) + NW'(den_c >> 1);
    q_s[0]   <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] dsh;
    logic          take;

    assign dsh  = NW'(den_s[k]) << SH;
    assign take = rem_s[k] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) vld_s[k+1] <= 1'b0;
      else     vld_s[k+1] <= vld_s[k];
      st_s[k+1]  <= st_s[k];
      den_s[k+1] <= den_s[k];
      rem_s[k+1] <= take ? rem_s[k] - dsh : rem_s[k];
      q_s[k+1]   <= take ? q_s[k] | (QW'(1) << SH) : q_s[k];
    end
  end

  // Output register.
  logic [QW-1:0] dist_c;
  always_comb begin
    case (st_s[QW])
      ST_INTERP: dist_c = (q_s[QW] > Q8_FAR) ? Q8_FAR : q_s[QW];
      ST_FAR:    dist_c = Q8_FAR;
      ST_NEAR:   dist_c = Q8_NEAR;
      default:   dist_c = Q8_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld_s[QW];
    distance_q8  <= dist_c;
    range_status <= st_s[QW];
  end

endmodule

### rtl/rsl_check.sv
module rsl_check (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [rsl_pkg::QW-1:0] distance_q8,
  input rsl_pkg::status_t       range_status
);
  import rsl_pkg::*;

  // Every accepted beat comes back exactly once as a done strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, PIPE_LAT))
    else $error("result strobe does not match the accepted beat");

  a_busy_release: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy held outside reset");

  a_far: assert property (@(posedge clk) disable iff (rst)
    done && range_status == ST_FAR |-> distance_q8 == Q8_FAR)
    else $error("far clamp gives the wrong distance");

  a_noseg: assert property (@(posedge clk) disable iff (rst)
    done && range_status == ST_NOSEG |-> distance_q8 == Q8_NONE)
    else $error("error result carries a distance");

  a_interp_range: assert property (@(posedge clk) disable iff (rst)
    done && range_status == ST_INTERP |-> distance_q8 >= Q8_NEAR && distance_q8 <= Q8_FAR)
    else $error("interpolated distance out of range");

endmodule

bind ranging_sensor_linearizer_top rsl_check u_rsl_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .distance_q8  (distance_q8),
  .range_status (range_status)
);
